// ===== hw/rtl/assert_macros.svh =====
// Assertion macros used by the checker module of the brightness normaliser.
// Depends on nothing; included by name where concurrent checks are written.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check held off while reset is applied.
`define IBN_ASSERT(label, clk, rstn, prop) \
    label: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error("ibn check failed");

// Check that also runs while reset is applied.
`define IBN_ASSERT_ALWAYS(label, clk, prop) \
    label: assert property (@(posedge clk) prop) \
        else $error("ibn check failed");

`endif

// ===== hw/rtl/ibn_pkg.sv =====
// Shared types, constants and helper functions of the brightness normaliser.
// Has no dependencies; imported by the arithmetic unit, the top level and the checker.
package ibn_pkg;

    // Field and register widths.
    localparam int CHAN_W     = 8;
    localparam int BRIGHT_W   = 12;
    localparam int ASCALE_W   = 9;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 12;
    localparam int SUM_W      = 34;
    localparam int CNT_W      = 17;
    localparam int GAIN_W     = 16;
    localparam int BASE_W     = BRIGHT_W + 2;

    // Shared unit widths: one multiplier, one wide adder/subtractor.
    localparam int MUL_A_W = 18;
    localparam int MUL_B_W = 17;
    localparam int PROD_W  = MUL_A_W + MUL_B_W;
    localparam int ACC_W   = 50;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_BRIGHTNESS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ALPHA      = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DIS_ALPHA  = 2'd2;

    // Reset values.
    localparam logic [BRIGHT_W-1:0] BRIGHT_RESET    = 12'd922;
    localparam logic [ASCALE_W-1:0] ALPHA_RESET     = 9'd256;
    localparam logic [ASCALE_W-1:0] DIS_ALPHA_RESET = 9'd90;
    localparam logic [GAIN_W-1:0]   GAIN_RESET      = 16'd4096;

    // Arithmetic constants.
    localparam logic [CNT_W-1:0]   MAX_PIXELS     = 17'd65536;
    localparam logic [MUL_A_W-1:0] PIX_WEIGHT_MAX = 18'd195075;
    // floor(x/3) equals (x*683)>>11 for every x up to 765.
    localparam logic [MUL_B_W-1:0] GRAY_RECIP     = 17'd683;
    localparam logic [ACC_W-1:0]   ROUND_Q12      = 50'd2048;
    localparam logic [ACC_W-1:0]   ROUND_Q8       = 50'd128;

    // Operation presented to the shared arithmetic unit.
    typedef struct packed {
        logic [MUL_A_W-1:0] mul_a;
        logic [MUL_B_W-1:0] mul_b;
        logic [ACC_W-1:0]   add_x;
        logic [ACC_W-1:0]   add_y;
        logic               add_sub;
    } alu_op_t;

    // Clamp a shifted product to the 8-bit channel range.
    function automatic logic [CHAN_W-1:0] sat8(input logic [38:0] v);
        return (v > 39'd255) ? 8'hFF : v[CHAN_W-1:0];
    endfunction

endpackage

// ===== hw/rtl/icon_brightness_normaliser.sv =====
// Top level of the icon brightness normaliser: sequencer, registers, output stage.
// Depends on ibn_pkg and ibn_alu.
//
// Usage: the host streams an ARGB image twice over the s_ channel. A word
// with s_mode low is a measure pixel and gives no result; s_last on a
// measure pixel closes the pass and sets the gain from the mean
// alpha-weighted brightness. A word with s_mode high is an apply pixel
// and gives one word on the m_ channel: gain-scaled colour, scaled alpha
// and a gray disabled-state version.
// Every step runs through one shared multiplier and one wide adder under
// a small sequencer, so s_ready is high only while the sequencer is idle.
// A measure pixel runs a multiply and an accumulate step; a closing
// measure pixel then also computes the gain (14 shift-add steps and
// 16 restoring divide steps). An apply pixel runs through its multiply
// and rounding steps, then waits to enter the output register for as
// long as the receiver holds m_ready low on the previous word.
// A stalled output word stays in the register, unchanged, until taken.
// Reset (aresetn low, synchronous) clears the accumulators, sets the gain
// to 1.0 and loads the register defaults. Configuration writes through
// cfg_wr_en, cfg_index and cfg_wdata take effect at once, with no wait.
module icon_brightness_normaliser (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_wr_en,
    input  logic [ibn_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [ibn_pkg::CFG_DATA_W-1:0]  cfg_wdata,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic                            s_mode,
    input  logic [ibn_pkg::CHAN_W-1:0]      s_red,
    input  logic [ibn_pkg::CHAN_W-1:0]      s_green,
    input  logic [ibn_pkg::CHAN_W-1:0]      s_blue,
    input  logic [ibn_pkg::CHAN_W-1:0]      s_opacity,
    input  logic                            s_last,
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic [ibn_pkg::CHAN_W-1:0]      m_out_red,
    output logic [ibn_pkg::CHAN_W-1:0]      m_out_green,
    output logic [ibn_pkg::CHAN_W-1:0]      m_out_blue,
    output logic [ibn_pkg::CHAN_W-1:0]      m_out_opacity,
    output logic [ibn_pkg::CHAN_W-1:0]      m_gray_level,
    output logic [ibn_pkg::CHAN_W-1:0]      m_gray_opacity
);
    import ibn_pkg::*;

    // Sequencer states.
    localparam logic [4:0] ST_IDLE    = 5'd0;
    localparam logic [4:0] ST_M_MUL   = 5'd1;
    localparam logic [4:0] ST_M_ACC   = 5'd2;
    localparam logic [4:0] ST_G_START = 5'd3;
    localparam logic [4:0] ST_G_DEN   = 5'd4;
    localparam logic [4:0] ST_G_MUL   = 5'd5;
    localparam logic [4:0] ST_G_HALF  = 5'd6;
    localparam logic [4:0] ST_G_DIV   = 5'd7;
    localparam logic [4:0] ST_G_DONE  = 5'd8;
    localparam logic [4:0] ST_A_RED   = 5'd9;
    localparam logic [4:0] ST_A_GRN   = 5'd10;
    localparam logic [4:0] ST_A_BLU   = 5'd11;
    localparam logic [4:0] ST_A_ALP   = 5'd12;
    localparam logic [4:0] ST_A_SUM   = 5'd13;
    localparam logic [4:0] ST_A_GRY   = 5'd14;
    localparam logic [4:0] ST_A_GAL   = 5'd15;
    localparam logic [4:0] ST_A_OUT   = 5'd16;

    logic [4:0] state_reg, state_next;
    logic [3:0] iter_reg, iter_next;

    // Captured input word.
    logic              last_reg, last_next;
    logic [CHAN_W-1:0] red_in_reg, red_in_next;
    logic [CHAN_W-1:0] grn_in_reg, grn_in_next;
    logic [CHAN_W-1:0] blu_in_reg, blu_in_next;
    logic [CHAN_W-1:0] op_in_reg, op_in_next;

    // Configuration and persistent state.
    logic [BRIGHT_W-1:0] bright_reg, bright_next;
    logic [ASCALE_W-1:0] alpha_reg, alpha_next;
    logic [ASCALE_W-1:0] dis_reg, dis_next;
    logic [SUM_W-1:0]    wsum_reg, wsum_next;
    logic [CNT_W-1:0]    count_reg, count_next;
    logic [GAIN_W-1:0]   gain_reg, gain_next;

    // Gain division working registers.
    logic [PROD_W-1:0] den_reg, den_next;
    logic [PROD_W-1:0] mcand_reg, mcand_next;
    logic [ACC_W-1:0]  num_reg, num_next;
    logic [ACC_W-1:0]  dsh_reg, dsh_next;
    logic [GAIN_W-1:0] quot_reg, quot_next;

    // Apply results in progress.
    logic [CHAN_W-1:0] red_reg, red_next;
    logic [CHAN_W-1:0] grn_reg, grn_next;
    logic [CHAN_W-1:0] blu_reg, blu_next;
    logic [CHAN_W-1:0] op_reg, op_next;
    logic [CHAN_W-1:0] gray_reg, gray_next;
    logic [CHAN_W-1:0] gop_reg, gop_next;

    // Output register.
    logic              m_valid_reg, m_valid_next;
    logic [CHAN_W-1:0] o_red_reg, o_red_next;
    logic [CHAN_W-1:0] o_grn_reg, o_grn_next;
    logic [CHAN_W-1:0] o_blu_reg, o_blu_next;
    logic [CHAN_W-1:0] o_op_reg, o_op_next;
    logic [CHAN_W-1:0] o_gray_reg, o_gray_next;
    logic [CHAN_W-1:0] o_gop_reg, o_gop_next;

    alu_op_t           alu_op;
    logic [PROD_W-1:0] prod;
    logic [ACC_W:0]    sum;
    logic [BASE_W-1:0] base;
    logic [9:0]        pix_sum;
    logic [9:0]        out_sum;

    ibn_alu u_alu (
        .aclk (aclk),
        .op   (alu_op),
        .prod (prod),
        .sum  (sum)
    );

    assign base    = {bright_reg, 2'b00};
    assign pix_sum = 10'(red_in_reg) + 10'(grn_in_reg) + 10'(blu_in_reg);
    assign out_sum = 10'(red_reg) + 10'(grn_reg) + 10'(blu_reg);
    assign s_ready = (state_reg == ST_IDLE);

    // Sequencer, configuration writes and output handshake.
    always_comb begin
        state_next   = state_reg;
        iter_next    = iter_reg;
        last_next    = last_reg;
        red_in_next  = red_in_reg;
        grn_in_next  = grn_in_reg;
        blu_in_next  = blu_in_reg;
        op_in_next   = op_in_reg;
        bright_next  = bright_reg;
        alpha_next   = alpha_reg;
        dis_next     = dis_reg;
        wsum_next    = wsum_reg;
        count_next   = count_reg;
        gain_next    = gain_reg;
        den_next     = den_reg;
        mcand_next   = mcand_reg;
        num_next     = num_reg;
        dsh_next     = dsh_reg;
        quot_next    = quot_reg;
        red_next     = red_reg;
        grn_next     = grn_reg;
        blu_next     = blu_reg;
        op_next      = op_reg;
        gray_next    = gray_reg;
        gop_next     = gop_reg;
        m_valid_next = m_valid_reg && !m_ready;
        o_red_next   = o_red_reg;
        o_grn_next   = o_grn_reg;
        o_blu_next   = o_blu_reg;
        o_op_next    = o_op_reg;
        o_gray_next  = o_gray_reg;
        o_gop_next   = o_gop_reg;
        alu_op       = '0;

        // Register writes.
        if (cfg_wr_en) begin
            unique case (cfg_index)
                CFG_BRIGHTNESS: bright_next = cfg_wdata[BRIGHT_W-1:0];
                CFG_ALPHA:      alpha_next  = cfg_wdata[ASCALE_W-1:0];
                CFG_DIS_ALPHA:  dis_next    = cfg_wdata[ASCALE_W-1:0];
                default:        ;
            endcase
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    last_next   = s_last;
                    red_in_next = s_red;
                    grn_in_next = s_green;
                    blu_in_next = s_blue;
                    op_in_next  = s_opacity;
                    state_next  = s_mode ? ST_A_RED : ST_M_MUL;
                end
            end

            // Measure: weight the channel sum by alpha, then accumulate while fewer than MAX_PIXELS are counted.
            ST_M_MUL: begin
                alu_op.mul_a = MUL_A_W'(pix_sum);
                alu_op.mul_b = MUL_B_W'(op_in_reg);
                state_next   = ST_M_ACC;
            end
            ST_M_ACC: begin
                alu_op.add_x = ACC_W'(wsum_reg);
                alu_op.add_y = ACC_W'(prod);
                if (count_reg < MAX_PIXELS) begin
                    wsum_next  = sum[SUM_W-1:0];
                    count_next = count_reg + CNT_W'(1);
                end
                state_next = last_reg ? ST_G_START : ST_IDLE;
            end

            // Gain: an empty pass takes the base directly.
            ST_G_START: begin
                if (count_reg == '0) begin
                    gain_next  = GAIN_W'(base);
                    state_next = ST_IDLE;
                end else begin
                    alu_op.mul_a = PIX_WEIGHT_MAX;
                    alu_op.mul_b = count_reg;
                    state_next   = ST_G_DEN;
                end
            end
            ST_G_DEN: begin
                alu_op.add_x = ACC_W'(wsum_reg);
                alu_op.add_y = ACC_W'(prod);
                den_next     = prod;
                mcand_next   = sum[PROD_W-1:0];
                num_next     = '0;
                iter_next    = 4'(BASE_W - 1);
                state_next   = ST_G_MUL;
            end
            // Shift-add multiply of the base by (den + wsum), MSB first.
            ST_G_MUL: begin
                alu_op.add_x = num_reg << 1;
                alu_op.add_y = base[iter_reg] ? ACC_W'(mcand_reg) : '0;
                num_next     = sum[ACC_W-1:0];
                if (iter_reg == '0) begin
                    state_next = ST_G_HALF;
                end else begin
                    iter_next = iter_reg - 4'd1;
                end
            end
            // Add half the divisor so the quotient rounds half up.
            ST_G_HALF: begin
                alu_op.add_x = num_reg;
                alu_op.add_y = ACC_W'(den_reg >> 1);
                num_next     = sum[ACC_W-1:0];
                dsh_next     = ACC_W'(den_reg) << (GAIN_W - 1);
                quot_next    = '0;
                iter_next    = 4'(GAIN_W - 1);
                state_next   = ST_G_DIV;
            end
            // Restoring division, one quotient bit a cycle.
            ST_G_DIV: begin
                alu_op.add_x   = num_reg;
                alu_op.add_y   = dsh_reg;
                alu_op.add_sub = 1'b1;
                if (!sum[ACC_W]) begin
                    num_next = sum[ACC_W-1:0];
                end
                quot_next = {quot_reg[GAIN_W-2:0], ~sum[ACC_W]};
                dsh_next  = dsh_reg >> 1;
                if (iter_reg == '0) begin
                    state_next = ST_G_DONE;
                end else begin
                    iter_next = iter_reg - 4'd1;
                end
            end
            ST_G_DONE: begin
                gain_next  = quot_reg;
                wsum_next  = '0;
                count_next = '0;
                state_next = ST_IDLE;
            end

            // Apply: one multiply a cycle, each product rounded or scaled in the cycle after it.
            ST_A_RED: begin
                alu_op.mul_a = MUL_A_W'(gain_reg);
                alu_op.mul_b = MUL_B_W'(red_in_reg);
                state_next   = ST_A_GRN;
            end
            ST_A_GRN: begin
                alu_op.mul_a = MUL_A_W'(gain_reg);
                alu_op.mul_b = MUL_B_W'(grn_in_reg);
                alu_op.add_x = ACC_W'(prod);
                alu_op.add_y = ROUND_Q12;
                red_next     = sat8(sum[50:12]);
                state_next   = ST_A_BLU;
            end
            ST_A_BLU: begin
                alu_op.mul_a = MUL_A_W'(gain_reg);
                alu_op.mul_b = MUL_B_W'(blu_in_reg);
                alu_op.add_x = ACC_W'(prod);
                alu_op.add_y = ROUND_Q12;
                grn_next     = sat8(sum[50:12]);
                state_next   = ST_A_ALP;
            end
            ST_A_ALP: begin
                alu_op.mul_a = MUL_A_W'(op_in_reg);
                alu_op.mul_b = MUL_B_W'(alpha_reg);
                alu_op.add_x = ACC_W'(prod);
                alu_op.add_y = ROUND_Q12;
                blu_next     = sat8(sum[50:12]);
                state_next   = ST_A_SUM;
            end
            ST_A_SUM: begin
                alu_op.mul_a = MUL_A_W'(out_sum);
                alu_op.mul_b = GRAY_RECIP;
                alu_op.add_x = ACC_W'(prod);
                alu_op.add_y = ROUND_Q8;
                op_next      = sat8(sum[46:8]);
                state_next   = ST_A_GRY;
            end
            ST_A_GRY: begin
                alu_op.mul_a = MUL_A_W'(op_reg);
                alu_op.mul_b = MUL_B_W'(dis_reg);
                gray_next    = prod[18:11];
                state_next   = ST_A_GAL;
            end
            ST_A_GAL: begin
                alu_op.add_x = ACC_W'(prod);
                alu_op.add_y = ROUND_Q8;
                gop_next     = sat8(sum[46:8]);
                state_next   = ST_A_OUT;
            end
            // Hand the word over once the output register is free.
            ST_A_OUT: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next = 1'b1;
                    o_red_next   = red_reg;
                    o_grn_next   = grn_reg;
                    o_blu_next   = blu_reg;
                    o_op_next    = op_reg;
                    o_gray_next  = gray_reg;
                    o_gop_next   = gop_reg;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control and persistent state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            iter_reg    <= '0;
            bright_reg  <= BRIGHT_RESET;
            alpha_reg   <= ALPHA_RESET;
            dis_reg     <= DIS_ALPHA_RESET;
            wsum_reg    <= '0;
            count_reg   <= '0;
            gain_reg    <= GAIN_RESET;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            iter_reg    <= iter_next;
            bright_reg  <= bright_next;
            alpha_reg   <= alpha_next;
            dis_reg     <= dis_next;
            wsum_reg    <= wsum_next;
            count_reg   <= count_next;
            gain_reg    <= gain_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        last_reg   <= last_next;
        red_in_reg <= red_in_next;
        grn_in_reg <= grn_in_next;
        blu_in_reg <= blu_in_next;
        op_in_reg  <= op_in_next;
        den_reg    <= den_next;
        mcand_reg  <= mcand_next;
        num_reg    <= num_next;
        dsh_reg    <= dsh_next;
        quot_reg   <= quot_next;
        red_reg    <= red_next;
        grn_reg    <= grn_next;
        blu_reg    <= blu_next;
        op_reg     <= op_next;
        gray_reg   <= gray_next;
        gop_reg    <= gop_next;
        o_red_reg  <= o_red_next;
        o_grn_reg  <= o_grn_next;
        o_blu_reg  <= o_blu_next;
        o_op_reg   <= o_op_next;
        o_gray_reg <= o_gray_next;
        o_gop_reg  <= o_gop_next;
    end

    assign m_valid        = m_valid_reg;
    assign m_out_red      = o_red_reg;
    assign m_out_green    = o_grn_reg;
    assign m_out_blue     = o_blu_reg;
    assign m_out_opacity  = o_op_reg;
    assign m_gray_level   = o_gray_reg;
    assign m_gray_opacity = o_gop_reg;

endmodule

// ===== hw/rtl/ibn_alu.sv =====
// Shared arithmetic unit: a registered multiplier and a wide adder/subtractor.
// Depends on ibn_pkg for widths and the operation struct.
module ibn_alu (
    input  logic                        aclk,
    input  ibn_pkg::alu_op_t            op,
    output logic [ibn_pkg::PROD_W-1:0]  prod,
    output logic [ibn_pkg::ACC_W:0]     sum
);
    import ibn_pkg::*;

    logic [PROD_W-1:0] prod_reg;

    // The product is registered before anything adds to it.
    always_ff @(posedge aclk) begin
        prod_reg <= PROD_W'(op.mul_a) * PROD_W'(op.mul_b);
    end

    assign prod = prod_reg;

    // The top bit is the carry of an add or the borrow of a subtract.
    always_comb begin
        if (op.add_sub) begin
            sum = {1'b0, op.add_x} - {1'b0, op.add_y};
        end else begin
            sum = {1'b0, op.add_x} + {1'b0, op.add_y};
        end
    end

endmodule

// ===== hw/rtl/ibn_checker.sv =====
// Port-level checks for the brightness normaliser, bound to the top level.
// Depends on ibn_pkg and the macros in assert_macros.svh.
`include "assert_macros.svh"

module ibn_checker (
    input logic                            aclk,
    input logic                            aresetn,
    input logic                            cfg_wr_en,
    input logic [ibn_pkg::CFG_IDX_W-1:0]   cfg_index,
    input logic [ibn_pkg::CFG_DATA_W-1:0]  cfg_wdata,
    input logic                            s_valid,
    input logic                            s_ready,
    input logic                            s_mode,
    input logic [ibn_pkg::CHAN_W-1:0]      s_red,
    input logic [ibn_pkg::CHAN_W-1:0]      s_green,
    input logic [ibn_pkg::CHAN_W-1:0]      s_blue,
    input logic [ibn_pkg::CHAN_W-1:0]      s_opacity,
    input logic                            s_last,
    input logic                            m_valid,
    input logic                            m_ready,
    input logic [ibn_pkg::CHAN_W-1:0]      m_out_red,
    input logic [ibn_pkg::CHAN_W-1:0]      m_out_green,
    input logic [ibn_pkg::CHAN_W-1:0]      m_out_blue,
    input logic [ibn_pkg::CHAN_W-1:0]      m_out_opacity,
    input logic [ibn_pkg::CHAN_W-1:0]      m_gray_level,
    input logic [ibn_pkg::CHAN_W-1:0]      m_gray_opacity
);
    import ibn_pkg::*;

    // Reset leaves the block idle with no word on offer.
    `IBN_ASSERT_ALWAYS(a_reset_idle, aclk, !aresetn |=> !m_valid && s_ready)

    // An accepted word keeps the sequencer busy for the next cycle.
    `IBN_ASSERT(a_busy_after_accept, aclk, aresetn, s_valid && s_ready |=> !s_ready)

    // A measure word never produces an output word straight away.
    `IBN_ASSERT(a_measure_silent, aclk, aresetn, s_valid && s_ready && !s_mode && !m_valid |=> !m_valid)

    // A stalled output word stays valid and keeps its red, gray level and gray opacity values.
    `IBN_ASSERT(a_out_hold, aclk, aresetn, m_valid && !m_ready |=> m_valid && $stable(m_out_red) && $stable(m_gray_level) && $stable(m_gray_opacity))

    // The gray level never exceeds every colour channel.
    `IBN_ASSERT(a_gray_bound, aclk, aresetn, m_valid |-> (m_gray_level <= m_out_red) || (m_gray_level <= m_out_green) || (m_gray_level <= m_out_blue))

endmodule

bind icon_brightness_normaliser ibn_checker u_ibn_checker (.*);
